@@ design/sha256_byte_stream_hasher_defines.svh @@
// assertion macros shared by the design files
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// property that holds on every clock edge outside reset
`define SHA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property whose consequent is checked in the cycle after the antecedent
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/sha_pkg.sv @@
package sha_pkg;
	localparam int QueueDepth = 4;
	localparam int OutDepth   = 8;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic       finish;
		logic [7:0] data;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_EMIT
	} eng_state_t;

	localparam word_t INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

@@ design/sha256_byte_stream_hasher.sv @@
// SHA-256 over a byte stream. Push one item per transaction: mode 0 adds data_byte to the
// message, mode 1 ends the message and queues the eight digest words (word_index 0..7,
// last_word on the eighth), after which the hasher starts a new empty message. Items go
// through a small input queue to the compression engine, which runs one round per cycle.
// Every 64th byte starts a compression (ST_ROUND, then ST_ADD), and a finish pads the
// block and compresses it, twice when more than 55 bytes sit in the final block, before the
// words enter an eight-entry result queue. The engine takes no new item while it compresses.
module sha256_byte_stream_hasher #(
	parameter int QueueDepth = sha_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha_pkg::*;

	item_t       in_item, q_item;
	logic        q_empty, q_take;
	logic [31:0] r_word;
	logic [2:0]  r_index;
	logic        r_valid, out_full;
	logic [34:0] out_data;

	assign in_item = '{finish: mode, data: data_byte};

	sha_queue #(.Width($bits(item_t)), .Depth(QueueDepth)) u_in_q (
		.clk, .arst_n,
		.wr_en(push), .wr_data(in_item), .full,
		.rd_en(q_take), .rd_data(q_item), .empty(q_empty)
	);

	sha_engine u_eng (
		.clk, .arst_n,
		.item(q_item), .item_valid(!q_empty), .item_take(q_take),
		.res_word(r_word), .res_index(r_index), .res_valid(r_valid), .res_room(!out_full)
	);

	sha_queue #(.Width(35), .Depth(OutDepth)) u_out_q (
		.clk, .arst_n,
		.wr_en(r_valid), .wr_data({r_word, r_index}), .full(out_full),
		.rd_en(pop), .rd_data(out_data), .empty
	);

	assign digest_word = out_data[34:3];
	assign word_index  = out_data[2:0];
	assign last_word   = (out_data[2:0] == 3'd7);
endmodule

@@ design/sha_queue.sv @@
`include "sha256_byte_stream_hasher_defines.svh"

module sha_queue #(
	parameter int Width = 9,
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [Width-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [Width-1:0] rd_data,
	output logic             empty
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	logic [Width-1:0] mem_q [Depth];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == (AW+1)'(Depth));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end

	`SHA_ASSERT(a_count_bound, count_q <= (AW+1)'(Depth), "queue count over depth")
	`SHA_ASSERT_NEXT(a_fill_grows, do_wr && !do_rd, count_q == $past(count_q) + 1'b1,
		"queue count did not grow on write")
	`SHA_ASSERT_NEXT(a_drain_shrinks, do_rd && !do_wr, count_q == $past(count_q) - 1'b1,
		"queue count did not shrink on read")
endmodule

@@ design/sha_engine.sv @@
`include "sha256_byte_stream_hasher_defines.svh"

module sha_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  sha_pkg::item_t      item,
	input  logic                item_valid,
	output logic                item_take,
	output logic [31:0]         res_word,
	output logic [2:0]          res_index,
	output logic                res_valid,
	input  logic                res_room
);
	import sha_pkg::*;

	eng_state_t state_q, state_d;

	word_t       h_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [5:0]  round_q;
	logic        final_q;     // current compression is part of a finish
	logic        second_q;    // a length-only block still follows
	logic [2:0]  emit_q;

	// round datapath
	word_t wt, s0, s1, w_next, big0, big1, ch, maj, t1, t2;
	logic  absorb, finish;

	assign absorb = item_valid && !item.finish;
	assign finish = item_valid && item.finish;

	always_comb begin
		s0     = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1     = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_next = s1 + w_q[9] + s0 + w_q[0];
		wt     = w_q[0];
		big1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1     = v_q[7] + big1 + ch + ROUND_K[round_q] + wt;
		big0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2     = big0 + maj;
	end

	always_comb begin
		state_d   = state_q;
		item_take = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_take = item_valid;
				if (absorb && fill_q == 6'd63) begin
					state_d = ST_ROUND;
				end else if (finish) begin
					state_d = ST_PAD;
				end
			end
			ST_ROUND: begin
				if (round_q == 6'd63) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (second_q) begin
					state_d = ST_PAD;
				end else if (final_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PAD:  state_d = ST_ROUND;
			ST_EMIT: begin
				if (res_room && emit_q == 3'd7) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign res_valid = (state_q == ST_EMIT);
	assign res_word  = h_q[emit_q];
	assign res_index = emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			bits_q   <= '0;
			round_q  <= '0;
			final_q  <= 1'b0;
			second_q <= 1'b0;
			emit_q   <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INIT_H[i];
			end
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (absorb) begin
						fill_q <= fill_q + 1'b1;
						if (fill_q == 6'd63) begin
							bits_q  <= bits_q + 64'd512;
							round_q <= '0;
							final_q <= 1'b0;
						end
					end else if (finish) begin
						bits_q   <= bits_q + {55'd0, fill_q, 3'd0};
						second_q <= (fill_q > 6'd55);
						final_q  <= 1'b1;
					end
				end
				ST_ROUND: round_q <= round_q + 1'b1;
				ST_ADD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					if (second_q) begin
						second_q <= 1'b0;
						fill_q   <= '0;
					end
					emit_q <= '0;
				end
				ST_PAD: begin
					round_q <= '0;
					if (!second_q) begin
						fill_q <= '0;
					end
				end
				ST_EMIT: begin
					if (res_room) begin
						emit_q <= emit_q + 1'b1;
						if (emit_q == 3'd7) begin
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= INIT_H[i];
							end
							bits_q  <= '0;
							fill_q  <= '0;
							final_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// working variables and message schedule, no reset needed
	always_ff @(posedge clk) begin
		word_t w_in;
		unique case (state_q)
			ST_IDLE: begin
				if (absorb) begin
					w_in = w_q[fill_q[5:2]];
					unique case (fill_q[1:0])
						2'd0: w_in[31:24] = item.data;
						2'd1: w_in[23:16] = item.data;
						2'd2: w_in[15:8]  = item.data;
						default: w_in[7:0] = item.data;
					endcase
					w_q[fill_q[5:2]] <= w_in;
					if (fill_q == 6'd63) begin
						for (int i = 0; i < 8; i++) begin
							v_q[i] <= h_q[i];
						end
					end
				end else if (finish) begin
					// pad byte then zeros past it in the current word
					w_in = w_q[fill_q[5:2]];
					unique case (fill_q[1:0])
						2'd0: w_in = 32'h80000000;
						2'd1: w_in = {w_in[31:24], 24'h800000};
						2'd2: w_in = {w_in[31:16], 16'h8000};
						default: w_in = {w_in[31:8], 8'h80};
					endcase
					for (int i = 0; i < 16; i++) begin
						if (4'(i) > fill_q[5:2]) begin
							w_q[i] <= '0;
						end
					end
					w_q[fill_q[5:2]] <= w_in;
				end
			end
			ST_ADD: begin
				// second block of a long finish is zeros up to the length
				if (second_q) begin
					for (int i = 0; i < 16; i++) begin
						w_q[i] <= '0;
					end
				end
			end
			ST_PAD: begin
				// the length goes into the last block only
				if (!second_q) begin
					w_q[14] <= bits_q[63:32];
					w_q[15] <= bits_q[31:0];
				end
				for (int i = 0; i < 8; i++) begin
					v_q[i] <= h_q[i];
				end
			end
			ST_ROUND: begin
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i+1];
				end
				w_q[15] <= w_next;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			default: ;
		endcase
	end

	`SHA_ASSERT(a_emit_only_final, !res_valid || final_q, "digest shown outside a finish")
	`SHA_ASSERT_NEXT(a_round_steps, state_q == ST_ROUND && round_q != 6'd63,
		state_q == ST_ROUND, "compression left early")
	`SHA_ASSERT(a_take_idle, !item_take || state_q == ST_IDLE, "item taken while busy")
endmodule
